[rtl/fcf_pkg.sv]
// shared types, constants and crc helper for the firmware chunk framer
package fcf_pkg;

    localparam int unsigned CFG_W   = 11;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned NBYTES  = 5;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  CMD_NO_REPLY = 8'hF0;
    localparam logic [15:0] CHUNK_MORE   = 16'h0400;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd255;
    localparam logic [CFG_W-1:0] CFG_OVERHEAD = 11'd4;

    // slot order inside one command
    localparam int unsigned SLOT_HDR_HI = 0;
    localparam int unsigned SLOT_HDR_LO = 1;
    localparam int unsigned SLOT_DATA   = 2;
    localparam int unsigned SLOT_CRC_HI = 3;
    localparam int unsigned SLOT_CRC_LO = 4;

    // m_axis_tuser bit positions
    localparam int unsigned USER_FRAME_END = 0;
    localparam int unsigned USER_NO_REPLY  = 1;
    localparam int unsigned USER_ITEM_LAST = 2;
    localparam int unsigned USER_W         = 3;

    typedef enum logic [2:0] {
        PH_HDR_HI = 3'b001,
        PH_HDR_LO = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [NBYTES-1:0]      mask;
        logic [NBYTES-1:0][7:0] bytes;
        logic                   frame_end;
        logic                   no_reply;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]} ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

[rtl/fcf_front.sv]
// front end: parses frame headers, cuts chunks, runs the crc and queues output commands
module fcf_front #(
    parameter int unsigned FRAME_LEN_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_byte,
    input  logic                       i_start,
    input  logic [fcf_pkg::CFG_W-1:0]  i_pkt_limit,
    input  logic                       i_full,
    output logic                       o_push,
    output fcf_pkg::t_cmd              o_cmd
);
    import fcf_pkg::*;

    localparam int unsigned FLB = FRAME_LEN_BITS;
    localparam int unsigned CW  = (FLB > CFG_W) ? FLB : CFG_W;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_hdr_hi, n_hdr_hi;
    logic [FLB-1:0]  r_len, n_len;
    logic [FLB-1:0]  r_sent, n_sent;
    logic [CW-1:0]   r_left, n_left;
    logic [15:0]     r_crc, n_crc;
    logic            r_flag, n_flag;

    t_phase          eff_phase;
    logic            accept;
    logic [CFG_W-1:0] cap;
    logic [FLB-1:0]  remaining;
    logic            more;
    logic [CW-1:0]   clen;
    logic [15:0]     chunk_hdr;
    logic [15:0]     hdr_word;
    logic [15:0]     crc_hdr;
    logic [15:0]     hdr_full;
    logic [FLB-1:0]  new_len;
    logic            open_chunk;
    logic [15:0]     crc0, crc1;
    logic [CW-1:0]   left0, left1;
    logic [FLB-1:0]  sent1;
    logic            done;
    logic            close_chunk;
    logic            cmd_flag;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign eff_phase = i_start ? PH_HDR_HI : r_phase;

    assign cap       = (i_pkt_limit > CFG_OVERHEAD) ? (i_pkt_limit - CFG_OVERHEAD)
                                                    : CFG_W'(1);
    assign remaining = r_len - r_sent;
    assign more      = CW'(remaining) > CW'(cap);
    assign clen      = more ? CW'(cap) : CW'(remaining);
    assign chunk_hdr = 16'(clen[FLB-1:0]) | (more ? CHUNK_MORE : 16'h0000);
    assign hdr_word  = (eff_phase == PH_HDR_LO) ? 16'h0000 : chunk_hdr;
    assign crc_hdr   = crc_byte(crc_byte(CRC_INIT, hdr_word[15:8]), hdr_word[7:0]);
    assign hdr_full  = {r_hdr_hi, i_byte};
    assign new_len   = hdr_full[FLB-1:0];

    assign open_chunk  = (r_left == '0);
    assign crc0        = open_chunk ? crc_hdr : r_crc;
    assign left0       = open_chunk ? clen : r_left;
    assign crc1        = crc_byte(crc0, i_byte);
    assign left1       = (left0 != '0) ? (left0 - CW'(1)) : '0;
    assign sent1       = r_sent + FLB'(1);
    assign done        = sent1 >= r_len;
    assign close_chunk = (left1 == '0) || done;
    assign cmd_flag    = (r_sent == '0) ? (i_byte == CMD_NO_REPLY) : r_flag;

    always_comb begin
        n_phase  = r_phase;
        n_hdr_hi = r_hdr_hi;
        n_len    = r_len;
        n_sent   = r_sent;
        n_left   = r_left;
        n_crc    = r_crc;
        n_flag   = r_flag;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_cmd.bytes[SLOT_HDR_HI] = hdr_word[15:8];
        o_cmd.bytes[SLOT_HDR_LO] = hdr_word[7:0];
        o_cmd.bytes[SLOT_DATA]   = i_byte;
        case (eff_phase)
            PH_HDR_HI: begin
                n_hdr_hi = i_byte;
                n_phase  = PH_HDR_LO;
            end
            PH_HDR_LO: begin
                n_len  = new_len;
                n_sent = '0;
                n_left = '0;
                n_flag = 1'b0;
                if (new_len == '0) begin
                    o_push = accept;
                    o_cmd.mask = '0;
                    o_cmd.mask[SLOT_HDR_HI] = 1'b1;
                    o_cmd.mask[SLOT_HDR_LO] = 1'b1;
                    o_cmd.mask[SLOT_CRC_HI] = 1'b1;
                    o_cmd.mask[SLOT_CRC_LO] = 1'b1;
                    o_cmd.bytes[SLOT_CRC_HI] = crc_hdr[15:8];
                    o_cmd.bytes[SLOT_CRC_LO] = crc_hdr[7:0];
                    o_cmd.frame_end = 1'b1;
                    n_phase = PH_HDR_HI;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                o_push = accept;
                o_cmd.mask[SLOT_HDR_HI] = open_chunk;
                o_cmd.mask[SLOT_HDR_LO] = open_chunk;
                o_cmd.mask[SLOT_DATA]   = 1'b1;
                o_cmd.mask[SLOT_CRC_HI] = close_chunk;
                o_cmd.mask[SLOT_CRC_LO] = close_chunk;
                o_cmd.bytes[SLOT_CRC_HI] = crc1[15:8];
                o_cmd.bytes[SLOT_CRC_LO] = crc1[7:0];
                o_cmd.frame_end = done;
                o_cmd.no_reply  = cmd_flag;
                n_crc  = crc1;
                n_left = close_chunk ? '0 : left1;
                n_sent = sent1;
                n_flag = cmd_flag;
                if (done) begin
                    n_phase = PH_HDR_HI;
                    n_sent  = '0;
                    n_flag  = 1'b0;
                end
            end
            default: begin
                n_phase = PH_HDR_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR_HI;
            r_hdr_hi <= '0;
            r_len    <= '0;
            r_sent   <= '0;
            r_left   <= '0;
            r_crc    <= CRC_INIT;
            r_flag   <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_hdr_hi <= n_hdr_hi;
            r_len    <= n_len;
            r_sent   <= n_sent;
            r_left   <= n_left;
            r_crc    <= n_crc;
            r_flag   <= n_flag;
        end
    end

endmodule

[rtl/fcf_queue.sv]
// short command queue between front end and byte emitter
module fcf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output fcf_pkg::t_cmd o_head
);
    import fcf_pkg::*;

    localparam int unsigned PW = $clog2(QDEPTH);
    localparam int unsigned CNTW = $clog2(QDEPTH + 1);

    t_cmd            r_mem [QDEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CNTW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CNTW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/fcf_back.sv]
// back end: walks each queued command and emits one byte per beat into an output register
module fcf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  fcf_pkg::t_cmd                i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_data,
    output logic                         o_last,
    output logic [fcf_pkg::USER_W-1:0]   o_user
);
    import fcf_pkg::*;

    logic [NBYTES-1:0] r_sent;
    logic              r_valid;
    logic [7:0]        r_data;
    logic              r_last;
    logic [USER_W-1:0] r_user;

    logic [NBYTES-1:0] rem, pick;
    logic [7:0]        sel_byte;
    logic              is_last;
    logic              advance;
    logic              is_crc_lo;
    logic [USER_W-1:0] n_user;

    assign rem       = i_head.mask & ~r_sent;
    assign pick      = rem & (~rem + NBYTES'(1));
    assign is_last   = ((rem & ~pick) == '0);
    assign is_crc_lo = pick[SLOT_CRC_LO];
    assign advance   = i_head_valid && (!r_valid || i_ready);
    assign o_pop     = advance && is_last;

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NBYTES; i++) begin
            sel_byte = sel_byte | (pick[i] ? i_head.bytes[i] : 8'h00);
        end
        n_user = '0;
        n_user[USER_FRAME_END] = is_crc_lo && i_head.frame_end;
        n_user[USER_NO_REPLY]  = is_crc_lo && i_head.no_reply;
        n_user[USER_ITEM_LAST] = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_sent  <= is_last ? '0 : (r_sent | pick);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data <= sel_byte;
            r_last <= is_crc_lo;
            r_user <= n_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

    a_crc_lo_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |-> r_user[USER_ITEM_LAST])
        else $error("chunk end beat not marked as last of its item");

    a_sent_within_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((r_sent & ~i_head.mask) == '0))
        else $error("emitted slot mask outside head command");

    a_sent_clear_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_sent == '0))
        else $error("partial command progress with empty queue");

    a_pop_clears_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_sent == '0))
        else $error("slot progress not cleared after command retired");

endmodule

[rtl/firmware_chunk_framer_crc16.sv]
// top level of the firmware chunk framer with crc-16/ccitt-false per chunk
//
//  port group   dir  beat contents
//  s_axis_*     in   tdata[7:0] image byte, tuser[0] image start
//  m_axis_*     out  tdata[7:0] header/data/crc byte, tlast chunk end,
//                    tuser[0] frame end, [1] no reply expected, [2] last of item
//  apb          in   reg 0 at 0x0: packet size limit [10:0], reset 255
//
//  one input beat is taken per cycle while the 4-entry command queue has room
//  the output register drains one byte per cycle while a command is queued and m_axis_tready
//  is high: a data byte is one beat, a chunk boundary adds two header and two crc bytes
//  synchronous active-low reset, no clearing pass
//  stalls on m_axis back up through the queue into s_axis tready only
module firmware_chunk_framer_crc16 #(
    parameter int unsigned FRAME_LEN_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] image_byte
    input  logic        s_axis_tuser,  // [0] image_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [fcf_pkg::USER_W-1:0] m_axis_tuser, // [0] frame_end, [1] no_reply, [2] item_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fcf_pkg::*;

    logic [CFG_W-1:0] r_pkt_limit;
    logic             cfg_wr;
    logic             q_full, q_push, q_pop, q_valid;
    t_cmd             q_in, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'h0 : 32'(r_pkt_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_limit <= CFG_RESET;
        end else if (cfg_wr) begin
            r_pkt_limit <= pwdata[CFG_W-1:0];
        end
    end

    fcf_front #(
        .FRAME_LEN_BITS (FRAME_LEN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_start       (s_axis_tuser),
        .i_pkt_limit   (r_pkt_limit),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    fcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    fcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_user       (m_axis_tuser)
    );

endmodule
